FILE: design/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg - shared types and constants
// Digit count, field widths, item kinds, segment code table and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// number of display digits
	localparam int DIGITS = 8;

	localparam int VALUE_W = 27;
	localparam int POS_OUT_W = 3;
	localparam int SEG_W = 8;
	localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int BCD_W = 4 * DIGITS;
	localparam int CNT_W = $clog2(VALUE_W);

	// item kinds carried in tuser
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// largest number shown, 10^DIGITS - 1
	function automatic logic [63:0] max_shown(input int n);
		logic [63:0] lim;
		lim = 64'd1;
		for (int k = 0; k < n; k++) begin
			lim = lim * 64'd10;
		end
		return lim - 64'd1;
	endfunction

	localparam logic [63:0] MAX_SHOWN = max_shown(DIGITS);

	// common-cathode codes, bit0 = a ... bit6 = g
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	typedef struct packed {
		logic load;    // latch a new number, start conversion
		logic shift;   // one double-dabble step
		logic commit;  // write segment codes into the store
		logic tick;    // emit current digit, advance scan
	} ssd_cmd_t;

	typedef struct packed {
		logic shift_last;  // final conversion step in progress
	} ssd_sts_t;

endpackage

FILE: design/ssd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ctrl - sequencing controller
// Decodes accepted items and steps the datapath through a load conversion.
// ----------------------------------------------------------------------------
module ssd_ctrl
	import ssd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     in_kind,
	input  ssd_sts_t sts,
	output logic     idle,
	output ssd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_kind == KIND_LOAD)) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (sts.shift_last) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == ST_IDLE);
	assign cmd.load   = in_fire && (in_kind == KIND_LOAD);
	assign cmd.tick   = in_fire && (in_kind == KIND_TICK);
	assign cmd.shift  = (state_q == ST_SHIFT);
	assign cmd.commit = (state_q == ST_COMMIT);

endmodule

FILE: design/ssd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_dp - conversion and display datapath
// Saturation, shift-add-3 binary to decimal, segment store, scan counter
// and the output register.
// ----------------------------------------------------------------------------
module ssd_dp
	import ssd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssd_cmd_t             cmd,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 out_ready,
	output ssd_sts_t             sts,
	output logic                 out_valid,
	output logic [POS_OUT_W-1:0] out_pos,
	output logic [SEG_W-1:0]     out_seg
);

	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SEG_W-1:0]     store_q [DIGITS];
	logic [POS_W-1:0]     pos_q;
	logic                 valid_q;
	logic [POS_OUT_W-1:0] pos_out_q;
	logic [SEG_W-1:0]     seg_out_q;

	logic [VALUE_W-1:0] sat_value;
	logic [BCD_W-1:0]   bcd_adj;
	logic [31:0]        pos_ext;

	// clamp to the largest number the display can show
	always_comb begin
		if ({{(64-VALUE_W){1'b0}}, value} > MAX_SHOWN) sat_value = VALUE_W'(MAX_SHOWN);
		else sat_value = value;
	end

	// add 3 to each decimal digit of 5 or more before the shift
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5) bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			else bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
		end
	end

	assign sts.shift_last = (cnt_q == CNT_W'(VALUE_W - 1));
	assign pos_ext = 32'(pos_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= sat_value;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// segment store, right-aligned with leading zeros blanked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) store_q[i] <= '0;
		end else if (cmd.commit) begin
			for (int k = 0; k < DIGITS; k++) begin
				if ((k == 0) || (|(bcd_q >> (4 * k))))
					store_q[DIGITS-1-k] <= seg_code(bcd_q[4*k +: 4]);
				else
					store_q[DIGITS-1-k] <= '0;
			end
		end
	end

	// scan position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				valid_q <= 1'b1;
				if (pos_q == POS_W'(DIGITS - 1)) pos_q <= '0;
				else pos_q <= pos_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			pos_out_q <= pos_ext[POS_OUT_W-1:0];
			seg_out_q <= store_q[pos_q];
		end
	end

	assign out_valid = valid_q;
	assign out_pos   = pos_out_q;
	assign out_seg   = seg_out_q;

endmodule

FILE: design/seven_segment_decimal_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_decimal_scan_driver - multiplexed 8-digit display driver
// Loads a number into a right-aligned decimal segment store and, on each
// scan tick, emits the current digit select and its segment byte.
//
//   channel  | dir | tdata                         | tuser
//   ---------+-----+-------------------------------+---------------------
//   s_axis   | in  | value[26:0], zero pad to 32   | kind (0 load, 1 tick)
//   m_axis   | out | digit_position[2:0],          | -
//            |     | segments[10:3], zero pad to 16|
//
// the result of an accepted tick transfer is registered straight into the
// output register; a load latches and saturates the value, then runs
// 27 shift-add-3 steps (one per value bit), then writes the store
// input is held off during a load conversion and while an unread result
// waits on a stalled output
// reset clears the store to blank, the scan position to zero and the valid flag of the output
// ----------------------------------------------------------------------------
module seven_segment_decimal_scan_driver
	import ssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [26:0] value, [31:27] zero
	input  logic        s_tuser,   // [0] kind
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] digit_position, [10:3] segments, [15:11] zero
);

	ssd_cmd_t             cmd;
	ssd_sts_t             sts;
	logic                 ctrl_idle;
	logic                 in_fire;
	logic [POS_OUT_W-1:0] out_pos;
	logic [SEG_W-1:0]     out_seg;

	// take a new item only when idle and the output register can be refilled
	assign s_tready = ctrl_idle && (!m_tvalid || m_tready);
	assign in_fire  = s_tvalid && s_tready;

	ssd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_kind (s_tuser),
		.sts     (sts),
		.idle    (ctrl_idle),
		.cmd     (cmd)
	);

	ssd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (s_tdata[VALUE_W-1:0]),
		.out_ready (m_tready),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_pos   (out_pos),
		.out_seg   (out_seg)
	);

	// result packing
	assign m_tdata = {5'b0, out_seg, out_pos};

	// no input transfer while the conversion is stepping
	a_no_accept_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> !s_tready)
		else $error("input accepted during conversion");

	// an accepted tick always shows up on the master side
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> m_tvalid)
		else $error("tick produced no result");

	// store write ends the load sequence
	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> ctrl_idle)
		else $error("controller not idle after store write");

	// segment bit 7 and padding stay clear
	a_seg_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:10] == 6'd0))
		else $error("unused result bits set");

endmodule
